// File: sv/jer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jer_pkg
// Types, constants and helper functions shared by the joystick event router.
// ----------------------------------------------------------------------------
package jer_pkg;

    localparam int HATS  = 4;
    localparam int BALLS = 8;

    localparam int HIDX_W = (HATS > 1) ? $clog2(HATS) : 1;
    localparam int BIDX_W = (BALLS > 1) ? $clog2(BALLS) : 1;
    localparam int NH_W   = $clog2(HATS + 1);
    localparam int NB_W   = $clog2(BALLS + 1);

    // queue between front and back, power of two deep
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // raw event types, init flag masked off
    localparam logic [6:0] TYPE_BUTTON = 7'd1;
    localparam logic [6:0] TYPE_AXIS   = 7'd2;

    // report kinds
    localparam logic [1:0] KIND_AXIS   = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_HAT    = 2'd2;
    localparam logic [1:0] KIND_BALL   = 2'd3;

    // three-way axis state
    localparam logic [1:0] AX_NEG    = 2'd0;
    localparam logic [1:0] AX_CENTRE = 2'd1;
    localparam logic [1:0] AX_POS    = 2'd2;

    localparam logic [3:0] HAT_RESET = {AX_CENTRE, AX_CENTRE};

    // hat position bits
    localparam logic [3:0] HAT_UP    = 4'd1;
    localparam logic [3:0] HAT_RIGHT = 4'd2;
    localparam logic [3:0] HAT_DOWN  = 4'd4;
    localparam logic [3:0] HAT_LEFT  = 4'd8;

    typedef enum logic [1:0] {
        CFG_AXIS_COUNT = 2'd0,
        CFG_HAT_COUNT  = 2'd1,
        CFG_BALL_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_BUTTON,
        CMD_AXIS,
        CMD_HAT,
        CMD_BALL,
        CMD_UPDATE
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } back_state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [7:0]         index;
        logic               axis_sel;
        logic signed [15:0] value;
    } qent_t;

    typedef struct packed {
        logic  push;
        qent_t ent;
    } q_wr_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } q_rd_t;

    function automatic logic [3:0] hat_mask(input logic [1:0] xs, input logic [1:0] ys);
        logic [3:0] m;
        m = 4'd0;
        if (ys == AX_NEG) m = m | HAT_UP;
        if (ys == AX_POS) m = m | HAT_DOWN;
        if (xs == AX_NEG) m = m | HAT_LEFT;
        if (xs == AX_POS) m = m | HAT_RIGHT;
        return m;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [15:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {{17{b[15]}}, b};
        if (s[32] != s[31])
            return s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        return s[31:0];
    endfunction

endpackage

// File: sv/jer_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jer_if
// Event and report channel interfaces of the joystick event router.
// ----------------------------------------------------------------------------
interface jer_evt_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [7:0]         event_type;
    logic [7:0]         event_number;
    logic signed [15:0] event_value;

    modport source (output valid, action, event_type, event_number, event_value,
                    input ready);
    modport sink (input valid, action, event_type, event_number, event_value,
                  output ready);
endinterface

interface jer_rpt_if;
    logic               valid;
    logic               ready;
    logic [1:0]         report_kind;
    logic [7:0]         report_index;
    logic signed [15:0] report_value;
    logic signed [31:0] ball_dx;
    logic signed [31:0] ball_dy;
    logic               last;

    modport source (output valid, report_kind, report_index, report_value, ball_dx,
                    ball_dy, last, input ready);
    modport sink (input valid, report_kind, report_index, report_value, ball_dx,
                  ball_dy, last, output ready);
endinterface

// File: sv/jer_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jer_front
// Accepts raw events and update requests and sorts them into commands.
// ----------------------------------------------------------------------------
module jer_front (
    jer_evt_if.sink                    evt,
    input  logic [7:0]                 axis_count,
    input  logic [jer_pkg::NH_W-1:0]   nh,
    input  logic [jer_pkg::NB_W-1:0]   nb,
    input  logic                       full,
    output jer_pkg::q_wr_t             q_wr
);

    logic [6:0] type7;
    logic [7:0] rel;
    logic [7:0] rel_ball;
    logic       keep;
    jer_pkg::qent_t ent;

    always_comb
    begin
        type7    = evt.event_type[6:0];
        rel      = evt.event_number - axis_count;
        rel_ball = rel - (8'(nh) << 1);
        keep     = 1'b0;
        ent.cmd      = jer_pkg::CMD_BUTTON;
        ent.index    = evt.event_number;
        ent.axis_sel = 1'b0;
        ent.value    = evt.event_value;

        if (evt.action) begin
            ent.cmd = jer_pkg::CMD_UPDATE;
            keep    = 1'b1;
        end
        else if (type7 == jer_pkg::TYPE_BUTTON) begin
            keep = 1'b1;
        end
        else if (type7 == jer_pkg::TYPE_AXIS) begin
            if (evt.event_number < axis_count) begin
                ent.cmd = jer_pkg::CMD_AXIS;
                keep    = 1'b1;
            end
            else if ({1'b0, rel[7:1]} < 8'(nh)) begin
                ent.cmd      = jer_pkg::CMD_HAT;
                ent.index    = {1'b0, rel[7:1]};
                ent.axis_sel = rel[0];
                keep         = 1'b1;
            end
            else if ({1'b0, rel_ball[7:1]} < 8'(nb)) begin
                ent.cmd      = jer_pkg::CMD_BALL;
                ent.index    = {1'b0, rel_ball[7:1]};
                ent.axis_sel = rel_ball[0];
                keep         = 1'b1;
            end
        end
    end

    // dropped events are still taken, they just never reach the queue
    assign evt.ready = !full;
    assign q_wr.push = evt.valid && !full && keep;
    assign q_wr.ent  = ent;

endmodule

// File: sv/jer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jer_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module jer_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  jer_pkg::q_wr_t q_wr,
    input  logic           pop,
    output logic           full,
    output jer_pkg::q_rd_t q_rd
);

    localparam logic [jer_pkg::QPTR_W-1:0] QPTR_ONE = 1;

    jer_pkg::qent_t                 mem_reg [jer_pkg::QDEPTH];
    logic [jer_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [jer_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [jer_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_pop;

    assign full       = (count_reg == jer_pkg::QCNT_W'(jer_pkg::QDEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.ent   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_ONE;
        rd_ptr_next = rd_ptr_reg + QPTR_ONE;
        count_next  = count_reg;
        if (q_wr.push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!q_wr.push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (q_wr.push) wr_ptr_reg <= wr_ptr_next;
            if (do_pop)    rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            mem_reg[wr_ptr_reg] <= q_wr.ent;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !full)
        else $error("command queue written while full");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr.push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("command queue count did not follow a write");

endmodule

// File: sv/jer_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jer_back
// Carries out queued commands: button and axis reports, hat tracking, ball
// accumulation, ball flush, and holds the report output register.
// ----------------------------------------------------------------------------
module jer_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [jer_pkg::NB_W-1:0] nb,
    input  jer_pkg::q_rd_t           q_rd,
    output logic                     pop,
    jer_rpt_if.source                rpt
);

    jer_pkg::back_state_t           state_reg, state_next;
    logic [jer_pkg::BIDX_W-1:0]     flush_idx_reg, flush_idx_next;

    logic [3:0]                     hat_reg [jer_pkg::HATS];
    logic signed [31:0]             ball_x_reg [jer_pkg::BALLS];
    logic signed [31:0]             ball_y_reg [jer_pkg::BALLS];
    logic [jer_pkg::BALLS-1:0]      moved_reg;

    logic                           rpt_valid_reg, rpt_valid_next;
    logic [1:0]                     kind_reg, kind_next;
    logic [7:0]                     index_reg, index_next;
    logic signed [15:0]             value_reg, value_next;
    logic signed [31:0]             dx_reg, dx_next;
    logic signed [31:0]             dy_reg, dy_next;
    logic                           last_reg, last_next;

    jer_pkg::qent_t                 ent;
    logic                           out_free;
    logic                           load;
    logic [jer_pkg::HIDX_W-1:0]     hat_addr;
    logic [1:0]                     new_st;
    logic [1:0]                     cur_st;
    logic [3:0]                     hat_new;
    logic                           hat_we;
    logic [jer_pkg::BIDX_W-1:0]     ball_addr;
    logic signed [31:0]             cur_x, cur_y;
    logic signed [31:0]             acc_x, acc_y;
    logic                           ball_acc;
    logic                           ball_clr;
    logic                           more_after;
    logic                           flush_end;

    assign ent      = q_rd.ent;
    assign out_free = !rpt_valid_reg || rpt.ready;
    assign hat_addr = ent.index[jer_pkg::HIDX_W-1:0];
    assign cur_st   = ent.axis_sel ? hat_reg[hat_addr][3:2] : hat_reg[hat_addr][1:0];
    assign hat_new  = ent.axis_sel ? {new_st, hat_reg[hat_addr][1:0]}
                                   : {hat_reg[hat_addr][3:2], new_st};

    assign ball_addr = (state_reg == jer_pkg::ST_FLUSH) ? flush_idx_reg
                                                        : ent.index[jer_pkg::BIDX_W-1:0];
    assign cur_x = ball_x_reg[ball_addr];
    assign cur_y = ball_y_reg[ball_addr];
    assign acc_x = ent.axis_sel ? cur_x : jer_pkg::sat_add(cur_x, ent.value);
    assign acc_y = ent.axis_sel ? jer_pkg::sat_add(cur_y, ent.value) : cur_y;

    assign flush_end = (jer_pkg::NB_W'(flush_idx_reg) + 1'b1 == nb);

    always_comb
    begin
        if (ent.value[15])
            new_st = jer_pkg::AX_NEG;
        else if (ent.value == '0)
            new_st = jer_pkg::AX_CENTRE;
        else
            new_st = jer_pkg::AX_POS;
    end

    // any moved ball left after the current one decides the last mark
    always_comb
    begin
        more_after = 1'b0;
        for (int j = 0; j < jer_pkg::BALLS; j++) begin
            if (moved_reg[j] && j > int'(flush_idx_reg) && j < int'(nb))
                more_after = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        flush_idx_next = flush_idx_reg;
        pop            = 1'b0;
        load           = 1'b0;
        hat_we         = 1'b0;
        ball_acc       = 1'b0;
        ball_clr       = 1'b0;
        kind_next      = kind_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        last_next      = last_reg;

        unique case (state_reg)
            jer_pkg::ST_IDLE:
            begin
                if (q_rd.valid) begin
                    unique case (ent.cmd)
                        jer_pkg::CMD_BUTTON, jer_pkg::CMD_AXIS:
                        begin
                            if (out_free) begin
                                load       = 1'b1;
                                pop        = 1'b1;
                                kind_next  = (ent.cmd == jer_pkg::CMD_AXIS) ?
                                             jer_pkg::KIND_AXIS : jer_pkg::KIND_BUTTON;
                                index_next = ent.index;
                                value_next = ent.value;
                                dx_next    = '0;
                                dy_next    = '0;
                                last_next  = 1'b1;
                            end
                        end
                        jer_pkg::CMD_HAT:
                        begin
                            if (new_st == cur_st) begin
                                pop = 1'b1;
                            end
                            else if (out_free) begin
                                pop        = 1'b1;
                                load       = 1'b1;
                                hat_we     = 1'b1;
                                kind_next  = jer_pkg::KIND_HAT;
                                index_next = ent.index;
                                value_next = {12'd0, jer_pkg::hat_mask(hat_new[1:0],
                                                                       hat_new[3:2])};
                                dx_next    = '0;
                                dy_next    = '0;
                                last_next  = 1'b1;
                            end
                        end
                        jer_pkg::CMD_BALL:
                        begin
                            pop      = 1'b1;
                            ball_acc = 1'b1;
                        end
                        jer_pkg::CMD_UPDATE:
                        begin
                            pop            = 1'b1;
                            flush_idx_next = '0;
                            if (nb != '0)
                                state_next = jer_pkg::ST_FLUSH;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            jer_pkg::ST_FLUSH:
            begin
                if (!moved_reg[flush_idx_reg] || out_free) begin
                    if (moved_reg[flush_idx_reg]) begin
                        load       = 1'b1;
                        ball_clr   = 1'b1;
                        kind_next  = jer_pkg::KIND_BALL;
                        index_next = 8'(flush_idx_reg);
                        value_next = '0;
                        dx_next    = cur_x;
                        dy_next    = cur_y;
                        last_next  = !more_after;
                    end
                    if (flush_end)
                        state_next = jer_pkg::ST_IDLE;
                    else
                        flush_idx_next = flush_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = jer_pkg::ST_IDLE;
            end
        endcase

        rpt_valid_next = load ? 1'b1 : (rpt.ready ? 1'b0 : rpt_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= jer_pkg::ST_IDLE;
            flush_idx_reg <= '0;
            rpt_valid_reg <= 1'b0;
            moved_reg     <= '0;
            for (int i = 0; i < jer_pkg::HATS; i++)
                hat_reg[i] <= jer_pkg::HAT_RESET;
            for (int i = 0; i < jer_pkg::BALLS; i++) begin
                ball_x_reg[i] <= '0;
                ball_y_reg[i] <= '0;
            end
        end
        else begin
            state_reg     <= state_next;
            flush_idx_reg <= flush_idx_next;
            rpt_valid_reg <= rpt_valid_next;
            if (hat_we)
                hat_reg[hat_addr] <= hat_new;
            if (ball_acc) begin
                ball_x_reg[ball_addr] <= acc_x;
                ball_y_reg[ball_addr] <= acc_y;
                moved_reg[ball_addr]  <= (acc_x != '0) || (acc_y != '0);
            end
            else if (ball_clr) begin
                ball_x_reg[ball_addr] <= '0;
                ball_y_reg[ball_addr] <= '0;
                moved_reg[ball_addr]  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        value_reg <= value_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        last_reg  <= last_next;
    end

    assign rpt.valid        = rpt_valid_reg;
    assign rpt.report_kind  = kind_reg;
    assign rpt.report_index = index_reg;
    assign rpt.report_value = value_reg;
    assign rpt.ball_dx      = dx_reg;
    assign rpt.ball_dy      = dy_reg;
    assign rpt.last         = last_reg;

    a_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jer_pkg::ST_FLUSH) |-> (jer_pkg::NB_W'(flush_idx_reg) < nb))
        else $error("ball flush index beyond ball count");

    a_hat_code: assert property (@(posedge clk) disable iff (!rst_n)
        hat_we |-> (hat_new[1:0] != 2'd3 && hat_new[3:2] != 2'd3))
        else $error("hat axis state written with an invalid code");

    a_ball_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        ball_clr |=> (!moved_reg[$past(flush_idx_reg)] && rpt_valid_reg))
        else $error("flushed ball still marked as moved or report missing");

endmodule

// File: sv/joystick_event_router.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_event_router
// Routes raw joystick events to axis, button, hat and trackball reports.
// ----------------------------------------------------------------------------
// evt carries raw events (action 0) and update requests (action 1); rpt
// carries reports, with last set on the final report of a transaction.
// Both use valid/ready. Axis, hat and ball counts are written through the
// cfg_we / cfg_index / cfg_data port, by the user only while the block is
// idle; the block does not enforce this. A report comes from the output
// register, fed through the command queue. Throughput: one event per cycle
// while rpt is ready and no update is flushing; an update request visits
// each configured ball accumulator in turn, one per cycle while rpt is ready.
// A two-entry command queue sits between the front and back ends, so events
// are still taken while a report waits in the output register; when rpt
// stalls and the queue fills, evt.ready drops.
// Reset sets axis_count to 2, no hats and no balls, centres every hat and
// clears all ball motion. The block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module joystick_event_router (
    input  logic        clk,
    input  logic        rst_n,
    jer_evt_if.sink     evt,
    jer_rpt_if.source   rpt,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]                   axis_count_reg;
    logic [2:0]                   hat_count_reg;
    logic [3:0]                   ball_count_reg;
    logic [jer_pkg::NH_W-1:0]     nh;
    logic [jer_pkg::NB_W-1:0]     nb;
    jer_pkg::q_wr_t               q_wr;
    jer_pkg::q_rd_t               q_rd;
    logic                         q_full;
    logic                         q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            axis_count_reg <= 8'd2;
            hat_count_reg  <= '0;
            ball_count_reg <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                jer_pkg::CFG_AXIS_COUNT: axis_count_reg <= cfg_data;
                jer_pkg::CFG_HAT_COUNT:  hat_count_reg  <= cfg_data[2:0];
                jer_pkg::CFG_BALL_COUNT: ball_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // counts above the built-in hat and ball numbers are capped
    assign nh = (32'(hat_count_reg) > jer_pkg::HATS) ?
                jer_pkg::NH_W'(jer_pkg::HATS) : jer_pkg::NH_W'(hat_count_reg);
    assign nb = (32'(ball_count_reg) > jer_pkg::BALLS) ?
                jer_pkg::NB_W'(jer_pkg::BALLS) : jer_pkg::NB_W'(ball_count_reg);

    jer_front u_front (
        .evt        (evt),
        .axis_count (axis_count_reg),
        .nh         (nh),
        .nb         (nb),
        .full       (q_full),
        .q_wr       (q_wr)
    );

    jer_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    jer_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .nb    (nb),
        .q_rd  (q_rd),
        .pop   (q_pop),
        .rpt   (rpt)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joystick event router. A queue-fed driver
// pushes raw events and update requests, a monitor predicts the reports of
// every accepted transaction and compares each report as it is taken. Phases
// at different axis, hat and ball counts, a run of large ball sums and
// random traffic with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int BIG_STEPS     = 8;
    localparam int SHOWN_ERRORS  = 10;

    localparam logic [7:0] EV_BUTTON = {1'b0, jer_pkg::TYPE_BUTTON};
    localparam logic [7:0] EV_AXIS   = {1'b0, jer_pkg::TYPE_AXIS};
    localparam logic [7:0] EV_INIT   = 8'h80;

    typedef struct packed {
        logic               action;
        logic [7:0]         etype;
        logic [7:0]         number;
        logic signed [15:0] value;
    } joy_event_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         index;
        logic signed [15:0] value;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               last;
    } report_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    jer_evt_if evt ();
    jer_rpt_if rpt ();

    joystick_event_router dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .rpt       (rpt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the router state
    logic [7:0]         axis_cnt;
    logic [2:0]         hat_cnt;
    logic [3:0]         ball_cnt;
    logic [1:0]         hat_x [jer_pkg::HATS];
    logic [1:0]         hat_y [jer_pkg::HATS];
    logic signed [31:0] motion_x [jer_pkg::BALLS];
    logic signed [31:0] motion_y [jer_pkg::BALLS];

    joy_event_t event_queue [$];
    report_t    report_queue [$];
    joy_event_t drv_item;
    report_t    seen_report;
    int         errors;
    int         cycle_count;
    logic       evt_fire;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // a stretch of each repeating window of cycle_count runs with no idling
    function automatic logic steady();
        return (cycle_count % 400) >= 250;
    endfunction

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] acc,
                                                     input logic signed [15:0] step);
        longint s;
        s = longint'(acc) + longint'(step);
        if (s > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (s < -64'sd2147483648)
            return 32'sh8000_0000;
        return s[31:0];
    endfunction

    // works out the reports of one accepted transaction and updates the shadow
    function automatic void route_event(input joy_event_t e);
        int         nh;
        int         nb;
        int         rel;
        int         h;
        int         b;
        logic [1:0] st;
        logic [3:0] mask;
        report_t    r;
        report_t    flush [$];
        nh = (hat_cnt > jer_pkg::HATS) ? jer_pkg::HATS : int'(hat_cnt);
        nb = (ball_cnt > jer_pkg::BALLS) ? jer_pkg::BALLS : int'(ball_cnt);
        r = '0;
        if (e.action)
        begin
            for (int i = 0; i < nb && flush.size() < MAX_REPORTS; i++)
            begin
                if (motion_x[i] != 0 || motion_y[i] != 0)
                begin
                    r.kind  = jer_pkg::KIND_BALL;
                    r.index = 8'(i);
                    r.dx    = motion_x[i];
                    r.dy    = motion_y[i];
                    flush.push_back(r);
                    motion_x[i] = '0;
                    motion_y[i] = '0;
                end
            end
            if (flush.size() != 0)
                flush[flush.size() - 1].last = 1'b1;
            foreach (flush[i])
                report_queue.push_back(flush[i]);
        end
        else
        begin
            r.last = 1'b1;
            if (e.etype[6:0] == jer_pkg::TYPE_BUTTON)
            begin
                r.kind  = jer_pkg::KIND_BUTTON;
                r.index = e.number;
                r.value = e.value;
                report_queue.push_back(r);
            end
            else if (e.etype[6:0] == jer_pkg::TYPE_AXIS)
            begin
                rel = int'(e.number) - int'(axis_cnt);
                if (rel < 0)
                begin
                    r.kind  = jer_pkg::KIND_AXIS;
                    r.index = e.number;
                    r.value = e.value;
                    report_queue.push_back(r);
                end
                else if (rel / 2 < nh)
                begin
                    h  = rel / 2;
                    st = (e.value < 0) ? jer_pkg::AX_NEG :
                         ((e.value == 0) ? jer_pkg::AX_CENTRE : jer_pkg::AX_POS);
                    if ((rel % 2 == 0) ? (st != hat_x[h]) : (st != hat_y[h]))
                    begin
                        if (rel % 2 == 0)
                            hat_x[h] = st;
                        else
                            hat_y[h] = st;
                        // left, down, right, up from msb to lsb
                        mask = {hat_x[h] == jer_pkg::AX_NEG, hat_y[h] == jer_pkg::AX_POS,
                                hat_x[h] == jer_pkg::AX_POS, hat_y[h] == jer_pkg::AX_NEG};
                        r.kind  = jer_pkg::KIND_HAT;
                        r.index = 8'(h);
                        r.value = {12'd0, mask};
                        report_queue.push_back(r);
                    end
                end
                else
                begin
                    rel = rel - 2 * nh;
                    if (rel / 2 < nb)
                    begin
                        b = rel / 2;
                        if (rel % 2 == 0)
                            motion_x[b] = clamp_add(motion_x[b], e.value);
                        else
                            motion_y[b] = clamp_add(motion_y[b], e.value);
                    end
                end
            end
        end
    endfunction

    function automatic string show(input report_t r);
        return $sformatf("kind %0d index %0d value %0d dx %0d dy %0d last %0b",
                         r.kind, r.index, r.value, r.dx, r.dy, r.last);
    endfunction

    function automatic void check_report(input report_t got);
        report_t want;
        if (report_queue.size() == 0)
        begin
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("unexpected report: %s", show(got));
        end
        else
        begin
            want = report_queue.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("report mismatch: expected %s, got %s", show(want), show(got));
            end
        end
    endfunction

    // monitor: both channels sampled at the rising edge
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            evt_fire = rst_n && evt.valid && evt.ready;
            if (rst_n && rpt.valid && rpt.ready)
            begin
                seen_report = '{rpt.report_kind, rpt.report_index, rpt.report_value,
                                rpt.ball_dx, rpt.ball_dy, rpt.last};
                check_report(seen_report);
            end
            if (evt_fire)
                route_event('{evt.action, evt.event_type, evt.event_number,
                              evt.event_value});
        end
    end

    // driver: next transaction once the current one has gone
    always @(negedge clk)
    begin
        if (rst_n && (!evt.valid || evt_fire))
        begin
            if (event_queue.size() != 0 && (steady() || $urandom_range(99) >= 6))
            begin
                drv_item = event_queue.pop_front();
                evt.valid        <= 1'b1;
                evt.action       <= drv_item.action;
                evt.event_type   <= drv_item.etype;
                evt.event_number <= drv_item.number;
                evt.event_value  <= drv_item.value;
            end
            else
                evt.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        rpt.ready <= rst_n && (steady() || $urandom_range(99) >= 6);
    end

    task automatic push_raw(input logic [7:0] etype, input int number, input int value);
        event_queue.push_back('{1'b0, etype, 8'(number), 16'(value)});
    endtask

    task automatic push_update();
        event_queue.push_back('{1'b1, 8'($urandom), 8'($urandom), 16'($urandom)});
    endtask

    task automatic write_reg(input jer_pkg::cfg_idx_t idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_data = 8'($urandom);
        case (idx)
            jer_pkg::CFG_AXIS_COUNT: axis_cnt = data;
            jer_pkg::CFG_HAT_COUNT:  hat_cnt  = data[2:0];
            jer_pkg::CFG_BALL_COUNT: ball_cnt = data[3:0];
            default: ;
        endcase
    endtask

    // upper data bits are noise above the register widths
    task automatic set_counts(input int axes, input int hats, input int balls);
        write_reg(jer_pkg::CFG_AXIS_COUNT, 8'(axes));
        write_reg(jer_pkg::CFG_HAT_COUNT, {5'($urandom), 3'(hats)});
        write_reg(jer_pkg::CFG_BALL_COUNT, {4'($urandom), 4'(balls)});
    endtask

    task automatic wait_idle();
        // sampled at the rising edge, where the driver's valid has settled
        while (event_queue.size() != 0 || evt.valid)
            @(posedge clk);
        while (report_queue.size() != 0)
            @(negedge clk);
        // ball motion transactions give no report, let the back end settle
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(3))
            0: return 16'sd0;
            1: return 16'($urandom_range(6)) - 16'sd3;
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic joy_event_t random_event();
        joy_event_t e;
        int         roll;
        int         base;
        int         span;
        int         num;
        int         nh;
        int         nb;
        nh = (hat_cnt > jer_pkg::HATS) ? jer_pkg::HATS : int'(hat_cnt);
        nb = (ball_cnt > jer_pkg::BALLS) ? jer_pkg::BALLS : int'(ball_cnt);
        e = '{1'b0, 8'($urandom), 8'($urandom), 16'($urandom)};
        roll = int'($urandom_range(99));
        if (roll < 10)
            e.action = 1'b1;
        else if (roll < 92)
        begin
            e.etype[7]   = 1'($urandom_range(1));
            e.etype[6:0] = (roll < 22) ? jer_pkg::TYPE_BUTTON : jer_pkg::TYPE_AXIS;
            e.value      = pick_value();
            case ($urandom_range(3))
                0: begin base = 0; span = int'(axis_cnt); end
                1: begin base = int'(axis_cnt); span = 2 * nh; end
                2: begin base = int'(axis_cnt) + 2 * nh; span = 2 * nb; end
                default: begin base = 0; span = 256; end
            endcase
            num = base + ((span > 0) ? int'($urandom_range(span - 1)) : 0);
            e.number = (num > 255) ? 8'($urandom) : 8'(num);
        end
        return e;
    endfunction

    task automatic random_phase(input int axes, input int hats, input int balls);
        set_counts(axes, hats, balls);
        repeat (PHASE_ITEMS) event_queue.push_back(random_event());
        wait_idle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = jer_pkg::CFG_AXIS_COUNT;
        cfg_data           = '0;
        evt.valid          = 1'b0;
        evt.action         = 1'b0;
        evt.event_type     = '0;
        evt.event_number   = '0;
        evt.event_value    = '0;
        rpt.ready          = 1'b0;
        errors             = 0;
        cycle_count        = 0;
        evt_fire           = 1'b0;
        axis_cnt           = 8'd2;
        hat_cnt            = '0;
        ball_cnt           = '0;
        for (int i = 0; i < jer_pkg::HATS; i++)
        begin
            hat_x[i] = jer_pkg::AX_CENTRE;
            hat_y[i] = jer_pkg::AX_CENTRE;
        end
        for (int i = 0; i < jer_pkg::BALLS; i++)
        begin
            motion_x[i] = '0;
            motion_y[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset counts: buttons, plain axes, ignored types, empty update
        push_raw(EV_BUTTON, 0, 0);
        push_raw(EV_BUTTON, 255, -32768);
        push_raw(EV_BUTTON | EV_INIT, 7, 32767);
        push_raw(EV_AXIS, 0, -32768);
        push_raw(EV_AXIS, 1, 32767);
        push_raw(EV_AXIS | EV_INIT, 1, 0);
        push_raw(EV_AXIS, 2, 1234);
        push_raw(8'h00, 3, 5);
        push_raw(8'h7F, 4, -5);
        push_raw(8'hFF, 0, 1);
        push_update();
        wait_idle();

        // one hat and two balls: unchanged hat state, every hat move, ball sums
        set_counts(2, 1, 2);
        push_raw(EV_AXIS, 2, 0);
        push_raw(EV_AXIS, 2, -5);
        push_raw(EV_AXIS, 3, -1);
        push_raw(EV_AXIS, 3, 0);
        push_raw(EV_AXIS | EV_INIT, 2, 100);
        push_raw(EV_AXIS, 3, 200);
        push_raw(EV_AXIS, 3, 300);
        push_raw(EV_AXIS, 4, 10);
        push_raw(EV_AXIS, 5, -20);
        push_raw(EV_AXIS, 7, 5);
        push_raw(EV_AXIS, 8, 99);
        push_update();
        push_update();
        wait_idle();

        // drive one ball to large sums on both axes
        set_counts(0, 0, 1);
        for (int i = 0; i < BIG_STEPS; i++)
        begin
            push_raw(EV_AXIS, 0, 32767);
            push_raw(EV_AXIS, 1, -32768);
        end
        push_raw(EV_AXIS, 0, -1);
        push_raw(EV_AXIS, 1, -1);
        push_update();
        wait_idle();

        random_phase(2, 4, 8);
        random_phase(0, 7, 15);
        random_phase(255, 4, 8);
        random_phase(250, 2, 3);
        random_phase(int'($urandom_range(20)), int'($urandom_range(7)),
                     int'($urandom_range(15)));
        random_phase(1, 4, 8);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
sv/jer_pkg.sv
sv/jer_if.sv
sv/jer_front.sv
sv/jer_queue.sv
sv/jer_back.sv
sv/joystick_event_router.sv
tb/testbench.sv
